@@ design/cascaded_biquad_with_peak_meter_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the biquad filter and peak meter
// Implication checks sampled on clk, held off while rst is high.
// ----------------------------------------------------------------------------
`ifndef CASCADED_BIQUAD_WITH_PEAK_METER_TOP_MACROS_SVH
`define CASCADED_BIQUAD_WITH_PEAK_METER_TOP_MACROS_SVH

// same-cycle implication
`define CBQPM_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CBQPM_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/cbqpm_pkg.sv @@
// ----------------------------------------------------------------------------
// cbqpm_pkg
// Shared types and constants of the biquad filter and peak meter.
// ----------------------------------------------------------------------------
`default_nettype none

package cbqpm_pkg;

  localparam int OUT_W   = 18;
  localparam int MAG_W   = 17;
  localparam int DATA_W  = 18;
  localparam int FF_W    = 54;
  localparam int FB_W    = 36;

  localparam int OUT_MAX = 131071;
  localparam int OUT_MIN = -131072;

  // gains and VU weights, Q.16
  localparam int GAIN_COMP  = 27007;
  localparam int GAIN_BOOST = 159030;
  localparam int VU_OLD_W   = 39322;
  localparam int VU_NEW_W   = 26214;
  localparam int Q16_HALF   = 32768;

  typedef enum logic [2:0] {
    REG_S0_FF,
    REG_S0_FB,
    REG_S1_FF,
    REG_S1_FB,
    REG_PRE,
    REG_BOOST
  } reg_idx_t;

  typedef struct packed {
    logic start;
    logic clear;
  } mac_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mac_stat_t;

endpackage

`default_nettype wire

@@ design/cbqpm_mac.sv @@
// ----------------------------------------------------------------------------
// cbqpm_mac
// Bit-serial multiply-accumulate: one multiplier bit per clock, LSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module cbqpm_mac #(
  parameter int MW    = 19,
  parameter int ACC_W = 40
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire cbqpm_pkg::mac_cmd_t                   cmd,
  input  wire logic signed [cbqpm_pkg::DATA_W-1:0]   a,
  input  wire logic signed [MW-1:0]                  b,
  input  wire logic signed [ACC_W-1:0]               init,
  output cbqpm_pkg::mac_stat_t                       stat,
  output logic signed [ACC_W-1:0]                    acc
);

  localparam int CNT_W = $clog2(MW);
  localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(MW - 1);

  logic signed [ACC_W-1:0] mcand;
  logic        [MW-1:0]    mplier;
  logic        [CNT_W-1:0] cnt;
  logic                    busy;
  logic                    done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && !cmd.start && (cnt == LAST_BIT);
      if (cmd.start) begin
        mcand  <= ACC_W'(a);
        mplier <= b;
        cnt    <= '0;
        busy   <= 1'b1;
        if (cmd.clear) begin
          acc <= init;
        end
      end else if (busy) begin
        // sign bit of the multiplier carries negative weight
        if (mplier[0]) begin
          acc <= (cnt == LAST_BIT) ? acc - mcand : acc + mcand;
        end
        mcand  <= mcand <<< 1;
        mplier <= mplier >> 1;
        cnt    <= cnt + 1'b1;
        if (cnt == LAST_BIT) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

`default_nettype wire

@@ design/cascaded_biquad_with_peak_meter_top.sv @@
// ----------------------------------------------------------------------------
// cascaded_biquad_with_peak_meter_top
// Two cascaded biquads, output gain, buffer peak meter and VU smoothing.
//
//   channel   direction  handshake                   payload
//   sample    in         sample_valid/sample_ready   sample_in, buffer_end
//   result    out        result_valid/result_ready   sample_out, running_peak,
//                                                    vu_level, buffer_end_out
//   config    in         APB psel/penable/pready     paddr, pwdata, prdata
//
// All products run through one bit-serial MAC with MW = max(COEF_WIDTH, 19)
// multiplier bits. A filtered sample takes 10 products (11 with the
// compensating gain), a bypassed one 0 or 1; buffer_end adds 2 for the VU
// update.
// One sample at a time; the next is taken while a result waits at the output.
// rst is synchronous and clears histories, peak, VU level and registers.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cascaded_biquad_with_peak_meter_top_macros.svh"

module cascaded_biquad_with_peak_meter_top #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int COEF_WIDTH   = 18
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  // sample channel
  input  wire logic                                   sample_valid,
  output logic                                        sample_ready,
  input  wire logic signed [SAMPLE_WIDTH-1:0]         sample_in,
  input  wire logic                                   buffer_end,
  // result channel
  output logic                                        result_valid,
  input  wire logic                                   result_ready,
  output logic signed [cbqpm_pkg::OUT_W-1:0]          sample_out,
  output logic        [cbqpm_pkg::MAG_W-1:0]          running_peak,
  output logic        [cbqpm_pkg::MAG_W-1:0]          vu_level,
  output logic                                        buffer_end_out,
  // configuration
  input  wire logic                                   psel,
  input  wire logic                                   penable,
  input  wire logic                                   pwrite,
  input  wire logic [5:0]                             paddr,
  input  wire logic [63:0]                            pwdata,
  output logic [63:0]                                 prdata,
  output logic                                        pready
);

  localparam int MW    = (COEF_WIDTH > 19) ? COEF_WIDTH : 19;
  localparam int ACC_W = MW + 21;
  localparam int QW    = SAMPLE_WIDTH + 18;
  localparam int PAD_W = cbqpm_pkg::FF_W + 3 * COEF_WIDTH;
  localparam int OW    = cbqpm_pkg::OUT_W;
  localparam int GW    = cbqpm_pkg::MAG_W;
  localparam int DW    = cbqpm_pkg::DATA_W;

  localparam logic signed [ACC_W-1:0] SAT_HI   = ACC_W'(cbqpm_pkg::OUT_MAX);
  localparam logic signed [ACC_W-1:0] SAT_LO   = ACC_W'(cbqpm_pkg::OUT_MIN);
  localparam logic signed [ACC_W-1:0] RND_COEF = ACC_W'(1) <<< (COEF_WIDTH - 4);
  localparam logic signed [ACC_W-1:0] RND_Q16  = ACC_W'(cbqpm_pkg::Q16_HALF);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ST0,
    S_ST1,
    S_GAIN,
    S_PEAK,
    S_VU,
    S_EMIT
  } state_t;

  // --------------------------------------------------------------------------
  // helpers
  // --------------------------------------------------------------------------
  function automatic logic signed [DW-1:0] to_q15(input logic signed [SAMPLE_WIDTH-1:0] v);
    logic signed [QW-1:0] t;
    t = QW'(v);
    t = t <<< 16;
    return DW'(t >>> SAMPLE_WIDTH);
  endfunction

  function automatic logic signed [COEF_WIDTH-1:0] coef_of(input logic [cbqpm_pkg::FF_W-1:0] r,
                                                           input int unsigned idx);
    logic [PAD_W-1:0] p;
    p = PAD_W'(r);
    return p[idx*COEF_WIDTH +: COEF_WIDTH];
  endfunction

  function automatic logic signed [OW-1:0] sat_out(input logic signed [ACC_W-1:0] v);
    if (v > SAT_HI) begin
      return OW'(cbqpm_pkg::OUT_MAX);
    end else if (v < SAT_LO) begin
      return OW'(cbqpm_pkg::OUT_MIN);
    end
    return OW'(v);
  endfunction

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  state_t state;
  logic [2:0] tix;
  logic       issued;

  logic [cbqpm_pkg::FF_W-1:0] s0_ff, s1_ff;
  logic [cbqpm_pkg::FB_W-1:0] s0_fb, s1_fb;
  logic                       pre_en, boost;

  logic signed [SAMPLE_WIDTH-1:0] raw, raw_h0, raw_h1;
  logic signed [DW-1:0]           fs_h0, fs_h1, ss_h0, ss_h1;
  logic signed [DW-1:0]           s0, s1, y;
  logic        [GW-1:0]           peak, vu;
  logic                           last;

  // --------------------------------------------------------------------------
  // MAC and operand selection
  // --------------------------------------------------------------------------
  cbqpm_pkg::mac_cmd_t  mac_cmd;
  cbqpm_pkg::mac_stat_t mac_stat;
  logic signed [DW-1:0]    mac_a;
  logic signed [MW-1:0]    mac_b;
  logic signed [ACC_W-1:0] mac_init;
  logic signed [ACC_W-1:0] acc;

  logic signed [DW-1:0]    x0, x1, x2;
  logic signed [ACC_W-1:0] acc_qc, acc_q16;
  logic signed [OW-1:0]    st_res, gain_res;
  logic        [GW-1:0]    vu_res, y_mag;
  logic                    last_term, emit_load;
  cbqpm_pkg::reg_idx_t     reg_sel;
  logic                    cfg_wr;

  always_comb begin
    x0 = to_q15(raw);
    x1 = to_q15(raw_h0);
    x2 = to_q15(raw_h1);

    mac_a    = '0;
    mac_b    = '0;
    mac_init = RND_Q16;
    case (state)
      S_ST0: begin
        mac_init = RND_COEF;
        case (tix)
          3'd0:    begin mac_a = x0;    mac_b = MW'(coef_of(s0_ff, 0)); end
          3'd1:    begin mac_a = x1;    mac_b = MW'(coef_of(s0_ff, 1)); end
          3'd2:    begin mac_a = x2;    mac_b = MW'(coef_of(s0_ff, 2)); end
          3'd3:    begin mac_a = fs_h0; mac_b = MW'(coef_of(cbqpm_pkg::FF_W'(s0_fb), 0)); end
          default: begin mac_a = fs_h1; mac_b = MW'(coef_of(cbqpm_pkg::FF_W'(s0_fb), 1)); end
        endcase
      end
      S_ST1: begin
        mac_init = RND_COEF;
        case (tix)
          3'd0:    begin mac_a = s0;    mac_b = MW'(coef_of(s1_ff, 0)); end
          3'd1:    begin mac_a = fs_h0; mac_b = MW'(coef_of(s1_ff, 1)); end
          3'd2:    begin mac_a = fs_h1; mac_b = MW'(coef_of(s1_ff, 2)); end
          3'd3:    begin mac_a = ss_h0; mac_b = MW'(coef_of(cbqpm_pkg::FF_W'(s1_fb), 0)); end
          default: begin mac_a = ss_h1; mac_b = MW'(coef_of(cbqpm_pkg::FF_W'(s1_fb), 1)); end
        endcase
      end
      S_GAIN: begin
        mac_a = pre_en ? s1 : x0;
        mac_b = pre_en ? MW'(cbqpm_pkg::GAIN_COMP) : MW'(cbqpm_pkg::GAIN_BOOST);
      end
      S_VU: begin
        if (tix == 3'd0) begin
          mac_a = $signed({1'b0, vu});
          mac_b = MW'(cbqpm_pkg::VU_OLD_W);
        end else begin
          mac_a = $signed({1'b0, peak});
          mac_b = MW'(cbqpm_pkg::VU_NEW_W);
        end
      end
      default: ;
    endcase

    mac_cmd.start = (state inside {S_ST0, S_ST1, S_GAIN, S_VU}) && !issued && !mac_stat.busy;
    mac_cmd.clear = (tix == 3'd0);

    case (state)
      S_ST0, S_ST1: last_term = (tix == 3'd4);
      S_VU:         last_term = (tix == 3'd1);
      default:      last_term = 1'b1;
    endcase

    acc_qc   = acc >>> (COEF_WIDTH - 3);
    acc_q16  = acc >>> 16;
    st_res   = sat_out(acc_qc);
    gain_res = sat_out(acc_q16);
    vu_res   = (acc_q16 > SAT_HI) ? GW'(cbqpm_pkg::OUT_MAX) : GW'(acc_q16);

    // most negative output folds onto the positive limit
    if (y[OW-1]) begin
      y_mag = (y == OW'(cbqpm_pkg::OUT_MIN)) ? GW'(cbqpm_pkg::OUT_MAX) : GW'(-y);
    end else begin
      y_mag = GW'(y);
    end

    emit_load = (state == S_EMIT) && (!result_valid || result_ready);
  end

  cbqpm_mac #(
    .MW    (MW),
    .ACC_W (ACC_W)
  ) u_mac (
    .clk  (clk),
    .rst  (rst),
    .cmd  (mac_cmd),
    .a    (mac_a),
    .b    (mac_b),
    .init (mac_init),
    .stat (mac_stat),
    .acc  (acc)
  );

  // --------------------------------------------------------------------------
  // configuration port
  // --------------------------------------------------------------------------
  assign reg_sel = cbqpm_pkg::reg_idx_t'(paddr[5:3]);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_comb begin
    case (reg_sel)
      cbqpm_pkg::REG_S0_FF: prdata = 64'(s0_ff);
      cbqpm_pkg::REG_S0_FB: prdata = 64'(s0_fb);
      cbqpm_pkg::REG_S1_FF: prdata = 64'(s1_ff);
      cbqpm_pkg::REG_S1_FB: prdata = 64'(s1_fb);
      cbqpm_pkg::REG_PRE:   prdata = 64'(pre_en);
      cbqpm_pkg::REG_BOOST: prdata = 64'(boost);
      default:              prdata = '0;
    endcase
  end

  assign sample_ready = (state == S_IDLE);

  // --------------------------------------------------------------------------
  // sequencer, state and output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      tix          <= '0;
      issued       <= 1'b0;
      result_valid <= 1'b0;
      s0_ff        <= '0;
      s0_fb        <= '0;
      s1_ff        <= '0;
      s1_fb        <= '0;
      pre_en       <= 1'b0;
      boost        <= 1'b0;
      raw_h0       <= '0;
      raw_h1       <= '0;
      fs_h0        <= '0;
      fs_h1        <= '0;
      ss_h0        <= '0;
      ss_h1        <= '0;
      peak         <= '0;
      vu           <= '0;
    end else begin
      if (cfg_wr) begin
        case (reg_sel)
          cbqpm_pkg::REG_S0_FF: s0_ff  <= pwdata[cbqpm_pkg::FF_W-1:0];
          cbqpm_pkg::REG_S0_FB: s0_fb  <= pwdata[cbqpm_pkg::FB_W-1:0];
          cbqpm_pkg::REG_S1_FF: s1_ff  <= pwdata[cbqpm_pkg::FF_W-1:0];
          cbqpm_pkg::REG_S1_FB: s1_fb  <= pwdata[cbqpm_pkg::FB_W-1:0];
          cbqpm_pkg::REG_PRE:   pre_en <= pwdata[0];
          cbqpm_pkg::REG_BOOST: boost  <= pwdata[0];
          default: ;
        endcase
      end

      if (emit_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end

      if (mac_cmd.start) begin
        issued <= 1'b1;
      end

      if (mac_stat.done) begin
        issued <= 1'b0;
        tix    <= last_term ? 3'd0 : tix + 3'd1;
      end

      case (state)
        S_IDLE: begin
          if (sample_valid) begin
            raw  <= sample_in;
            last <= buffer_end;
            tix  <= '0;
            if (pre_en) begin
              state <= S_ST0;
            end else if (boost) begin
              state <= S_GAIN;
            end else begin
              y     <= to_q15(sample_in);
              state <= S_PEAK;
            end
          end
        end
        S_ST0: begin
          if (mac_stat.done && last_term) begin
            s0    <= st_res;
            state <= S_ST1;
          end
        end
        S_ST1: begin
          if (mac_stat.done && last_term) begin
            // advance all histories once both sections have used them
            raw_h1 <= raw_h0;
            raw_h0 <= raw;
            fs_h1  <= fs_h0;
            fs_h0  <= s0;
            ss_h1  <= ss_h0;
            ss_h0  <= st_res;
            if (boost) begin
              y     <= st_res;
              state <= S_PEAK;
            end else begin
              s1    <= st_res;
              state <= S_GAIN;
            end
          end
        end
        S_GAIN: begin
          if (mac_stat.done) begin
            y     <= gain_res;
            state <= S_PEAK;
          end
        end
        S_PEAK: begin
          if (y_mag > peak) begin
            peak <= y_mag;
          end
          state <= last ? S_VU : S_EMIT;
        end
        S_VU: begin
          if (mac_stat.done && last_term) begin
            vu    <= vu_res;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_load) begin
            sample_out     <= y;
            running_peak   <= peak;
            vu_level       <= vu;
            buffer_end_out <= last;
            if (last) begin
              peak <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `CBQPM_ASSERT_NEXT(a_accept_leaves_idle, sample_valid && sample_ready, !sample_ready, "sample request taken but sequencer stayed idle")
  `CBQPM_ASSERT_IMP(a_mac_start_free, mac_cmd.start, !mac_stat.busy && !mac_stat.done, "MAC started while busy")
  `CBQPM_ASSERT_NEXT(a_peak_cleared, emit_load && last, peak == '0, "peak not cleared after buffer end")

endmodule

`default_nettype wire

@@ dv/cascaded_biquad_with_peak_meter_top_test.sv @@
// ----------------------------------------------------------------------------
// cascaded_biquad_with_peak_meter_top_test
// Drives audio samples through the two-stage biquad and peak meter in all
// four gain modes. A local fixed-point filter chain predicts every result
// (sample, buffer peak, VU level, end flag), and the monitor compares each
// accepted result against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cascaded_biquad_with_peak_meter_top_test;

  localparam int SW           = 16;
  localparam int CW           = 18;
  localparam int DRAIN_CYCLES = 400;
  localparam int RAND_PHASES  = 12;
  localparam int PHASE_ITEMS  = 64;

  typedef struct packed {
    logic signed [SW-1:0] smp;
    logic                 last;
  } sample_item_t;

  typedef struct {
    logic signed [cbqpm_pkg::OUT_W-1:0] smp;
    logic        [cbqpm_pkg::MAG_W-1:0] peak;
    logic        [cbqpm_pkg::MAG_W-1:0] vu;
    logic                               last;
  } meter_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 sample_valid = 1'b0;
  logic                 sample_ready;
  logic signed [SW-1:0] sample_in    = '0;
  logic                 buffer_end   = 1'b0;

  logic                               result_valid;
  logic                               result_ready = 1'b0;
  logic signed [cbqpm_pkg::OUT_W-1:0] sample_out;
  logic        [cbqpm_pkg::MAG_W-1:0] running_peak;
  logic        [cbqpm_pkg::MAG_W-1:0] vu_level;
  logic                               buffer_end_out;

  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [5:0]  paddr   = '0;
  logic [63:0] pwdata  = '0;
  logic [63:0] prdata;
  logic        pready;

  cascaded_biquad_with_peak_meter_top #(
    .SAMPLE_WIDTH(SW),
    .COEF_WIDTH  (CW)
  ) uut (
    .clk           (clk),
    .rst           (rst),
    .sample_valid  (sample_valid),
    .sample_ready  (sample_ready),
    .sample_in     (sample_in),
    .buffer_end    (buffer_end),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .sample_out    (sample_out),
    .running_peak  (running_peak),
    .vu_level      (vu_level),
    .buffer_end_out(buffer_end_out),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // filter settings as last written
  logic [cbqpm_pkg::FF_W-1:0] cfg_ff0 = '0;
  logic [cbqpm_pkg::FB_W-1:0] cfg_fb0 = '0;
  logic [cbqpm_pkg::FF_W-1:0] cfg_ff1 = '0;
  logic [cbqpm_pkg::FB_W-1:0] cfg_fb1 = '0;
  logic                       cfg_pre   = 1'b0;
  logic                       cfg_boost = 1'b0;

  // filter and meter state
  longint raw_h0 = 0, raw_h1 = 0;
  longint st0_h0 = 0, st0_h1 = 0;
  longint st1_h0 = 0, st1_h1 = 0;
  longint peak_q = 0, vu_q = 0;

  sample_item_t  sample_queue[$];
  meter_result_t predicted_out[$];
  int            fail_count = 0;

  function automatic longint sat18(longint v);
    if (v > cbqpm_pkg::OUT_MAX) return cbqpm_pkg::OUT_MAX;
    if (v < cbqpm_pkg::OUT_MIN) return cbqpm_pkg::OUT_MIN;
    return v;
  endfunction

  // round half up, then drop s fraction bits
  function automatic longint round_drop(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint biquad(longint x0, longint x1, longint x2, longint y1,
                                    longint y2, logic [cbqpm_pkg::FF_W-1:0] ff,
                                    logic [cbqpm_pkg::FB_W-1:0] fb);
    longint acc;
    acc = longint'($signed(ff[17:0])) * x0 + longint'($signed(ff[35:18])) * x1
        + longint'($signed(ff[53:36])) * x2
        + longint'($signed(fb[17:0])) * y1 + longint'($signed(fb[35:18])) * y2;
    return sat18(round_drop(acc, CW - 3));
  endfunction

  function automatic longint apply_gain(longint v, longint k);
    return sat18(round_drop(v * k, 16));
  endfunction

  task automatic run_filter_chain(input logic signed [SW-1:0] smp, input logic last);
    longint x0, s0, s1, y, mag;
    meter_result_t r;
    x0 = longint'(smp);
    if (cfg_pre) begin
      s0 = biquad(x0, raw_h0, raw_h1, st0_h0, st0_h1, cfg_ff0, cfg_fb0);
      // second stage sees the first stage's history before this sample
      s1 = biquad(s0, st0_h0, st0_h1, st1_h0, st1_h1, cfg_ff1, cfg_fb1);
      st0_h1 = st0_h0;
      st0_h0 = s0;
      st1_h1 = st1_h0;
      st1_h0 = s1;
      raw_h1 = raw_h0;
      raw_h0 = x0;
      y = cfg_boost ? s1 : apply_gain(s1, cbqpm_pkg::GAIN_COMP);
    end else begin
      y = cfg_boost ? apply_gain(x0, cbqpm_pkg::GAIN_BOOST) : x0;
    end
    mag = (y < 0) ? -y : y;
    if (mag > cbqpm_pkg::OUT_MAX) mag = cbqpm_pkg::OUT_MAX;
    if (mag > peak_q) peak_q = mag;
    r.smp  = y[cbqpm_pkg::OUT_W-1:0];
    r.peak = peak_q[cbqpm_pkg::MAG_W-1:0];
    if (last) begin
      vu_q = (cbqpm_pkg::VU_OLD_W * vu_q + cbqpm_pkg::VU_NEW_W * peak_q
              + cbqpm_pkg::Q16_HALF) >>> 16;
      if (vu_q > cbqpm_pkg::OUT_MAX) vu_q = cbqpm_pkg::OUT_MAX;
      peak_q = 0;
    end
    r.vu   = vu_q[cbqpm_pkg::MAG_W-1:0];
    r.last = last;
    predicted_out.push_back(r);
  endtask

  // sender: bursts of requests separated by random gaps
  int           burst_left = 0;
  int           gap_left   = 0;
  sample_item_t next_item;

  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else begin
      if (sample_valid && sample_ready) run_filter_chain(sample_in, buffer_end);
      if (!sample_valid || sample_ready) begin
        if (gap_left > 0 || sample_queue.size() == 0) begin
          sample_valid <= 1'b0;
          if (gap_left > 0) gap_left <= gap_left - 1;
        end else begin
          next_item = sample_queue.pop_front();
          sample_valid <= 1'b1;
          sample_in    <= next_item.smp;
          buffer_end   <= next_item.last;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            case ($urandom_range(0, 7))
              0, 1:    gap_left <= 0;
              2:       gap_left <= $urandom_range(1, 300);
              default: gap_left <= $urandom_range(1, 12);
            endcase
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // receiver: stretches of differing stall behaviour
  int rdy_mode = 0;
  int rdy_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (rdy_left == 0) begin
        rdy_mode <= $urandom_range(0, 3);
        rdy_left <= $urandom_range(8, 80);
      end else begin
        rdy_left <= rdy_left - 1;
      end
      case (rdy_mode)
        0:       result_ready <= 1'b1;
        1:       result_ready <= ($urandom_range(0, 3) != 0);
        2:       result_ready <= $urandom_range(0, 1);
        default: result_ready <= (rdy_left < 4);
      endcase
    end
  end

  task automatic check_field(input string name, input longint exp_v, input longint act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  meter_result_t exp_r;

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (predicted_out.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual sample_out %0d",
                 $time, sample_out);
        fail_count++;
      end else begin
        exp_r = predicted_out.pop_front();
        check_field("sample_out", longint'(exp_r.smp), longint'(sample_out));
        check_field("running_peak", longint'(exp_r.peak), longint'(running_peak));
        check_field("vu_level", longint'(exp_r.vu), longint'(vu_level));
        check_field("buffer_end_out", longint'(exp_r.last), longint'(buffer_end_out));
      end
    end
  end

  task automatic write_reg(input cbqpm_pkg::reg_idx_t idx, input logic [63:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      cbqpm_pkg::REG_S0_FF: cfg_ff0   = val[cbqpm_pkg::FF_W-1:0];
      cbqpm_pkg::REG_S0_FB: cfg_fb0   = val[cbqpm_pkg::FB_W-1:0];
      cbqpm_pkg::REG_S1_FF: cfg_ff1   = val[cbqpm_pkg::FF_W-1:0];
      cbqpm_pkg::REG_S1_FB: cfg_fb1   = val[cbqpm_pkg::FB_W-1:0];
      cbqpm_pkg::REG_PRE:   cfg_pre   = val[0];
      cbqpm_pkg::REG_BOOST: cfg_boost = val[0];
      default: ;
    endcase
  endtask

  task automatic set_filter(input logic [63:0] ff0, input logic [63:0] fb0,
                            input logic [63:0] ff1, input logic [63:0] fb1,
                            input logic [63:0] pre, input logic [63:0] boost);
    write_reg(cbqpm_pkg::REG_S0_FF, ff0);
    write_reg(cbqpm_pkg::REG_S0_FB, fb0);
    write_reg(cbqpm_pkg::REG_S1_FF, ff1);
    write_reg(cbqpm_pkg::REG_S1_FB, fb1);
    write_reg(cbqpm_pkg::REG_PRE, pre);
    write_reg(cbqpm_pkg::REG_BOOST, boost);
  endtask

  task automatic push_item(input logic signed [SW-1:0] smp, input logic last);
    sample_item_t it;
    it.smp  = smp;
    it.last = last;
    sample_queue.push_back(it);
  endtask

  // hold until every request has gone in and every result has come out
  task automatic wait_idle();
    do @(posedge clk);
    while (sample_queue.size() != 0 || sample_valid || predicted_out.size() != 0);
  endtask

  function automatic logic [17:0] rand_coef(int kind);
    case (kind)
      0:       return 18'($urandom);
      1:       return 18'($urandom_range(0, 16383) - 8192);
      2:       return 18'h0;
      default: return 18'(32768 + $urandom_range(0, 4095) - 2048);
    endcase
  endfunction

  function automatic logic signed [SW-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2:       return SW'($urandom_range(0, 511) - 256);
      default: return SW'($urandom);
    endcase
  endfunction

  localparam logic [17:0] Q_ONE = 18'h08000;
  localparam logic [17:0] C_MAX = 18'h1ffff;
  localparam logic [17:0] C_MIN = 18'h20000;

  initial begin
    int           count, len, kff, kfb;
    logic [63:0]  ff0, fb0, ff1, fb1, pre, boost;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // bypass, unity
    set_filter(0, 0, 0, 0, 0, 0);
    push_item(16'sh7fff, 1'b0);
    push_item(16'sh8000, 1'b1);
    push_item(16'sh0000, 1'b0);
    push_item(16'sh0001, 1'b0);
    push_item(-16'sh0001, 1'b1);
    wait_idle();

    // bypass, boosted
    write_reg(cbqpm_pkg::REG_BOOST, 1);
    push_item(16'sh7fff, 1'b0);
    push_item(16'sh8000, 1'b1);
    push_item(16'sd12345, 1'b1);
    wait_idle();

    // filter as identity, unscaled
    set_filter({18'h0, 18'h0, Q_ONE}, 0, {18'h0, 18'h0, Q_ONE}, 0, 1, 1);
    push_item(16'sh7fff, 1'b0);
    push_item(16'sh8000, 1'b0);
    push_item(16'sd100, 1'b1);
    wait_idle();

    // largest coefficients: saturate both ways, including the most negative output
    set_filter({3{C_MAX}}, {2{C_MAX}}, {3{C_MAX}}, {2{C_MAX}}, 1, 1);
    push_item(16'sh7fff, 1'b0);
    push_item(16'sh7fff, 1'b0);
    push_item(16'sh8000, 1'b0);
    push_item(16'sh8000, 1'b1);
    push_item(16'sh0000, 1'b0);
    wait_idle();

    // most negative coefficients with compensating gain
    set_filter({3{C_MIN}}, {2{C_MIN}}, {3{C_MIN}}, {2{C_MIN}}, 1, 0);
    push_item(16'sh8000, 1'b0);
    push_item(16'sh7fff, 1'b0);
    push_item(16'sh0001, 1'b0);
    push_item(-16'sh0001, 1'b1);
    wait_idle();

    // bypass for a while, then resume filtering from the held history
    write_reg(cbqpm_pkg::REG_PRE, 0);
    push_item(16'sd500, 1'b0);
    push_item(16'sd600, 1'b1);
    wait_idle();
    set_filter({rand_coef(1), rand_coef(1), rand_coef(3)}, {rand_coef(1), rand_coef(1)},
               {rand_coef(1), rand_coef(1), rand_coef(3)}, {rand_coef(1), rand_coef(1)},
               1, 1);
    push_item(16'sd700, 1'b0);
    push_item(-16'sd800, 1'b0);
    push_item(16'sd900, 1'b1);
    wait_idle();

    for (int p = 0; p < RAND_PHASES; p++) begin
      kff = $urandom_range(0, 3);
      kfb = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 2);
      ff0 = {rand_coef(kff), rand_coef(kff), rand_coef(kff == 0 ? 0 : 3)};
      fb0 = {rand_coef(kfb), rand_coef(kfb)};
      ff1 = {rand_coef(kff), rand_coef(kff), rand_coef(kff == 0 ? 0 : 3)};
      fb1 = {rand_coef(kfb), rand_coef(kfb)};
      pre   = (p < 8) ? 64'((p >> 1) & 1) : 64'($urandom_range(0, 1));
      boost = (p < 8) ? 64'(p & 1) : 64'($urandom_range(0, 1));
      if (p == RAND_PHASES - 2) begin
        // unused upper bits set at random
        ff0 = {$urandom, $urandom};
        fb0 = {$urandom, $urandom};
        ff1 = {$urandom, $urandom};
        fb1 = {$urandom, $urandom};
        pre   = {$urandom, $urandom};
        boost = {$urandom, $urandom};
      end else if (p == RAND_PHASES - 1) begin
        ff0 = '1;
        fb0 = '1;
        ff1 = '1;
        fb1 = '1;
        pre   = 1;
        boost = 0;
      end
      set_filter(ff0, fb0, ff1, fb1, pre, boost);
      count = 0;
      while (count < PHASE_ITEMS) begin
        len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 32);
        for (int i = 0; i < len; i++) push_item(rand_sample(), i == len - 1);
        count += len;
      end
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
